// ===== hdl/layer_alpha_compositor_unit_macros.svh =====
// Assertion macros used by the compositor top level.
`ifndef LAYER_ALPHA_COMPOSITOR_UNIT_MACROS_SVH
`define LAYER_ALPHA_COMPOSITOR_UNIT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define LAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds at a clock edge outside reset.
`define LAC_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/lac_pkg.sv =====
// Package with types and codes shared by the compositor modules.
`timescale 1ns / 1ps

package lac_pkg;

  // Default geometry of the framebuffer and of the output panel.
  localparam int unsigned LAC_MAX_SIDE      = 64;
  localparam int unsigned LAC_PANEL_COLUMNS = 32;

  // Action codes carried in the input tuser field.
  localparam logic [1:0] ACT_BLEND = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_X_LOW        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_HIGH       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_LOW        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PANEL_HEIGHT = 3'd4;

  // One stored RGB pixel, red in the top byte.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } lac_pixel_t;

endpackage

// ===== hdl/lac_ram.sv =====
// Generic single-port RAM with a registered read.
`timescale 1ns / 1ps

module lac_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write when enabled; the read returns the old contents in the next cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/lac_blend.sv =====
// Alpha blend datapath for the three color channels of one pixel.
`timescale 1ns / 1ps

module lac_blend
  import lac_pkg::*;
(
  input  lac_pixel_t new_pix_i,
  input  logic [7:0] alpha_i,
  input  lac_pixel_t old_pix_i,
  output lac_pixel_t blend_pix_o
);

  logic [8:0] inv_alpha;

  // Each channel is (new*a >> 8) + (old*(256-a) >> 8); the sum never exceeds 255.
  function automatic logic [7:0] blend_chan(logic [7:0] n, logic [7:0] o, logic [7:0] a,
                                            logic [8:0] ia);
    logic [15:0] p_new;
    logic [16:0] p_old;
    logic [8:0]  sum;
    p_new = 16'(n) * 16'(a);
    p_old = 17'(o) * 17'(ia);
    sum   = 9'(p_new[15:8]) + p_old[16:8];
    return sum[7:0];
  endfunction

  assign inv_alpha = 9'd256 - 9'(alpha_i);

  assign blend_pix_o.red   = blend_chan(new_pix_i.red,   old_pix_i.red,   alpha_i, inv_alpha);
  assign blend_pix_o.green = blend_chan(new_pix_i.green, old_pix_i.green, alpha_i, inv_alpha);
  assign blend_pix_o.blue  = blend_chan(new_pix_i.blue,  old_pix_i.blue,  alpha_i, inv_alpha);

endmodule

// ===== hdl/layer_alpha_compositor_unit.sv =====
// Top level of the alpha blending framebuffer compositor.
//
//  Channel   Direction  Handshake                    Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tuser action, tdata coordinate and RGBA
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata pixel, color, LED index; tuser flag
//  cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i register, cfg_data_i value
//
// A blend or read item is accepted in the idle state, which reads the pixel memory; in the
// finishing state a blend item is blended and written back over the single memory port, and
// the output register is loaded. A clear item sweeps the memory one entry per cycle over all
// MAX_SIDE*MAX_SIDE entries, then returns its result. After reset the same sweep runs and no
// item is accepted; configuration writes are taken at any time. A stalled output holds the
// item in its finishing state until the output register frees up.
`timescale 1ns / 1ps
`include "layer_alpha_compositor_unit_macros.svh"

module layer_alpha_compositor_unit
  import lac_pkg::*;
#(
  parameter int unsigned MAX_SIDE      = LAC_MAX_SIDE,
  parameter int unsigned PANEL_COLUMNS = LAC_PANEL_COLUMNS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Input items.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [9:0] x_pos, [19:10] y_pos, [27:20] new_red, [35:28] new_green, [43:36] new_blue,
  // [51:44] new_alpha, [55:52] zero
  input  logic [55:0]          s_axis_tdata,
  // [1:0] action
  input  logic [1:0]           s_axis_tuser,
  // Result items.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [47:24] packed_color,
  // [56:48] led_index, [63:57] zero
  output logic [63:0]          m_axis_tdata,
  // [0] led_valid
  output logic [0:0]           m_axis_tuser,
  // Configuration writes.
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [8:0]           cfg_data_i
);

  localparam int unsigned SideW = $clog2(MAX_SIDE);
  localparam int unsigned Depth = MAX_SIDE * MAX_SIDE;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  // Sequencer states.
  localparam logic [1:0] ST_CLR  = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic             clr_rsp_q, clr_rsp_d;

  logic [8:0] x_low_q, x_high_q, y_low_q, y_high_q;
  logic [4:0] panel_height_q;

  logic [1:0]       action_q;
  logic [AddrW-1:0] addr_q;
  lac_pixel_t       new_pix_q;
  logic [7:0]       alpha_q;
  logic [8:0]       led_index_q;
  logic             led_valid_q;

  logic             out_valid_q, out_valid_d;
  logic [63:0]      out_data_q;
  logic             out_user_q;

  logic             in_xfer, out_load;
  logic [9:0]       in_x, in_y;
  logic [SideW-1:0] cx, cy;
  logic [AddrW-1:0] in_addr;
  logic [14:0]      hx;
  logic             in_led_valid;
  logic [8:0]       in_led_index;

  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  lac_pixel_t       ram_wdata, ram_rdata, blend_pix, res_pix;
  lac_pixel_t       in_pix;

  // Offset of a coordinate inside its window after clamping.
  function automatic logic [SideW-1:0] clamp_offset(logic [9:0] v_raw, logic [8:0] lo_raw,
                                                    logic [8:0] hi_raw);
    logic signed [11:0] v, lo, hi, top;
    v   = 12'(signed'(v_raw));
    lo  = 12'(signed'(lo_raw));
    hi  = 12'(signed'(hi_raw));
    top = lo + 12'(MAX_SIDE - 1);
    if (hi > top) hi = top;
    if (hi < lo) hi = lo;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return SideW'(v - lo);
  endfunction

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q        <= 9'h1F6;
      x_high_q       <= 9'd42;
      y_low_q        <= 9'h1F6;
      y_high_q       <= 9'd42;
      panel_height_q <= 5'd8;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_X_LOW:        x_low_q        <= cfg_data_i;
        REG_X_HIGH:       x_high_q       <= cfg_data_i;
        REG_Y_LOW:        y_low_q        <= cfg_data_i;
        REG_Y_HIGH:       y_high_q       <= cfg_data_i;
        REG_PANEL_HEIGHT: panel_height_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  // Input decode: clamped store address and the panel index.
  assign in_x    = s_axis_tdata[9:0];
  assign in_y    = s_axis_tdata[19:10];
  assign cx      = clamp_offset(in_x, x_low_q, x_high_q);
  assign cy      = clamp_offset(in_y, y_low_q, y_high_q);
  assign in_addr = AddrW'(32'(cy) * MAX_SIDE) + AddrW'(cx);

  assign in_led_valid = !in_x[9] && (in_x < 10'(PANEL_COLUMNS)) &&
                        !in_y[9] && (in_y < 10'(panel_height_q));
  assign hx = 15'(in_x) * 15'(panel_height_q);

  // Odd columns run upward, even columns run downward from the flipped row.
  always_comb begin
    in_led_index = 9'd0;
    if (in_led_valid) begin
      if (in_x[0]) begin
        in_led_index = hx[8:0] + in_y[8:0];
      end else begin
        in_led_index = hx[8:0] + 9'(panel_height_q - 5'd1 - in_y[4:0]);
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

  // Sequencer: clearing sweep, idle, and the finishing state of an item.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    clr_rsp_d = clr_rsp_q;
    unique case (state_q)
      ST_CLR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == LastAddr) begin
          clr_cnt_d = '0;
          state_d   = clr_rsp_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          clr_rsp_d = (s_axis_tuser == ACT_CLEAR);
          state_d   = (s_axis_tuser == ACT_CLEAR) ? ST_CLR : ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          clr_rsp_d = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      clr_cnt_q <= '0;
      clr_rsp_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      clr_rsp_q <= clr_rsp_d;
    end
  end

  // Item registers, loaded on an input transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q    <= s_axis_tuser;
      addr_q      <= in_addr;
      new_pix_q   <= in_pix;
      alpha_q     <= s_axis_tdata[51:44];
      led_index_q <= in_led_index;
      led_valid_q <= in_led_valid;
    end
  end

  assign in_pix.red   = s_axis_tdata[27:20];
  assign in_pix.green = s_axis_tdata[35:28];
  assign in_pix.blue  = s_axis_tdata[43:36];

  // Memory port: sweep writes, the read at accept, and the blend write-back.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = blend_pix;
    unique case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt_q;
        ram_wdata = '0;
      end
      ST_IDLE: ram_addr = in_addr;
      ST_FIN:  ram_we   = out_load && (action_q == ACT_BLEND) && !clr_rsp_q;
      default: ;
    endcase
  end

  lac_ram #(
    .WIDTH($bits(lac_pixel_t)),
    .DEPTH(Depth)
  ) u_pixel_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  lac_blend u_blend (
    .new_pix_i  (new_pix_q),
    .alpha_i    (alpha_q),
    .old_pix_i  (ram_rdata),
    .blend_pix_o(blend_pix)
  );

  // Pixel reported for the item after its action.
  always_comb begin
    res_pix = ram_rdata;
    if (clr_rsp_q) begin
      res_pix = '0;
    end else if (action_q == ACT_BLEND) begin
      res_pix = blend_pix;
    end
  end

  // Output register.
  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {7'd0, led_index_q, res_pix, res_pix.blue, res_pix.green, res_pix.red};
      out_user_q <= led_valid_q;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_user_q;

  // A blend or read item always goes straight to its finishing cycle.
  `LAC_ASSERT(a_item_to_fin, in_xfer && (s_axis_tuser != ACT_CLEAR) |=> (state_q == ST_FIN),
              "item did not reach its finishing cycle")
  // The pixel memory is written only by the sweep or by a blend write-back.
  `LAC_ASSERT(a_we_source, ram_we |-> (state_q == ST_CLR) || (state_q == ST_FIN && out_load),
              "memory write outside sweep or write-back")
  // The sweep visits one entry per cycle without skipping.
  `LAC_ASSERT(a_sweep_step,
              (state_q == ST_CLR) && (clr_cnt_q != LastAddr) |=>
                (clr_cnt_q == $past(clr_cnt_q) + 1'b1),
              "clearing sweep skipped an entry")
  // A result is never loaded over one that is still waiting.
  `LAC_ASSERT_NEVER(a_no_overwrite, out_load && out_valid_q && !m_axis_tready,
                    "result register overwritten")

endmodule
